// File: hdl/bprv_pkg.sv
// ----------------------------------------------------------------------------
// Board position record validator package
// Shared constants, status codes and the result record type.
// ----------------------------------------------------------------------------
`default_nettype none

package bprv_pkg;

	// Largest piece count that a header may declare
	localparam int MAX_PIECES = 32;

	// Fixed layout of the section payload
	localparam int HDR_BYTES  = 16;
	localparam int REC_BYTES  = 4;
	localparam int N_SQUARES  = 90;
	localparam int SQ_MAX     = N_SQUARES - 1;
	localparam int SQ_W       = $clog2(N_SQUARES);

	// Byte offset counter reaches the end of the largest legal payload
	localparam int CNT_W      = $clog2(HDR_BYTES + REC_BYTES * MAX_PIECES + 1);
	// Declared piece count as stored
	localparam int PC_W       = $clog2(MAX_PIECES + 1);
	// Declared piece count as reported on the output
	localparam int OUT_PC_W   = 6;

	// Result queue
	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	// Result kinds
	localparam logic KIND_PIECE   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_SHORT       = 4'd1,
		ST_VERSION     = 4'd2,
		ST_HDR_SIZE    = 4'd3,
		ST_VARIANT     = 4'd4,
		ST_SIDE        = 4'd5,
		ST_FLAGS       = 4'd6,
		ST_MOVE_ZERO   = 4'd7,
		ST_TOO_MANY    = 4'd8,
		ST_RESERVED    = 4'd9,
		ST_SIZE        = 4'd10,
		ST_PIECE_CODE  = 4'd11,
		ST_SQ_RANGE    = 4'd12,
		ST_PIECE_FLAGS = 4'd13,
		ST_DUPLICATE   = 4'd14
	} status_t;

	typedef struct packed {
		logic                kind;
		status_t             status;
		logic [15:0]         error_offset;
		logic                mover_side;
		logic [15:0]         move_number;
		logic [OUT_PC_W-1:0] pieces_declared;
		logic                canonical;
		logic                piece_side;
		logic [2:0]          piece_kind;
		logic [6:0]          board_square;
		logic                last;
	} result_t;

endpackage : bprv_pkg

`default_nettype wire

// File: hdl/board_position_record_validator_top.sv
// ----------------------------------------------------------------------------
// Board position record validator
// Streams a board-position section payload one byte per item, checks the
// header and every piece record, and reports piece results and a summary.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+-------------------------------------------
//  config  | cfg_valid / cfg_ready | payload_length
//  input   | in_valid  / in_ready  | data_byte, first
//  output  | out_valid / out_ready | kind, status, error_offset, mover_side,
//          |                       | move_number, pieces_declared, canonical,
//          |                       | piece_side, piece_kind, board_square, last
//
// One input item is taken per cycle while in_ready is high. An item is checked
// in the cycle after it is accepted, while it sits in the input register, and
// its results (none, one or two) go into an eight-entry result queue in that
// same cycle. The input side stalls only while the queue cannot take two more
// results for the item in flight and two for a new one; the output side drains
// one result per cycle while out_ready is high. Reset leaves the block idle
// until a byte marked first arrives. The config port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module board_position_record_validator_top
	import bprv_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,

	input  wire logic                cfg_valid,
	output      logic                cfg_ready,
	input  wire logic [15:0]         payload_length,

	input  wire logic                in_valid,
	output      logic                in_ready,
	input  wire logic [7:0]          data_byte,
	input  wire logic                first,

	output      logic                out_valid,
	input  wire logic                out_ready,
	output      logic                kind,
	output      logic [3:0]          status,
	output      logic [15:0]         error_offset,
	output      logic                mover_side,
	output      logic [15:0]         move_number,
	output      logic [OUT_PC_W-1:0] pieces_declared,
	output      logic                canonical,
	output      logic                piece_side,
	output      logic [2:0]          piece_kind,
	output      logic [6:0]          board_square,
	output      logic                last
);

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [15:0] plen_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			plen_q <= payload_length;
		end
	end

	// ------------------------------------------------------------------
	// Input register
	// ------------------------------------------------------------------
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       first_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1  <= data_byte;
			first_s1 <= first;
		end
	end

	// ------------------------------------------------------------------
	// Run state
	// ------------------------------------------------------------------
	logic [CNT_W-1:0]     cnt_q,   cnt_d;
	logic [N_SQUARES-1:0] taken_q, taken_d;
	logic [SQ_W-1:0]      prev_q,  prev_d;
	logic                 havep_q, havep_d;
	logic                 ord_q,   ord_d;
	logic                 hside_q, hside_d;
	logic [15:0]          hmove_q, hmove_d;
	logic [PC_W-1:0]      hcount_q, hcount_d;
	logic [31:0]          fb_q,    fb_d;
	logic                 fin_q,   fin_d;

	logic    push0, push1;
	result_t res0, res1;

	// ------------------------------------------------------------------
	// Per-byte check
	// ------------------------------------------------------------------
	always_comb begin : step
		logic [CNT_W-1:0] off;
		logic [1:0]       pos;
		logic [31:0]      fb;
		logic [15:0]      lo;
		logic [15:0]      hi;
		logic [7:0]       code;
		logic [7:0]       sq;
		logic [CNT_W-1:0] base;
		logic             fail;
		status_t          fst;
		logic [15:0]      foff;
		logic             piece;
		logic [15:0]      end_len;

		// A byte marked first starts from a cleared run
		cnt_d    = first_s1 ? '0    : cnt_q;
		taken_d  = first_s1 ? '0    : taken_q;
		prev_d   = first_s1 ? '0    : prev_q;
		havep_d  = first_s1 ? 1'b0  : havep_q;
		ord_d    = first_s1 ? 1'b1  : ord_q;
		hside_d  = first_s1 ? 1'b0  : hside_q;
		hmove_d  = first_s1 ? '0    : hmove_q;
		hcount_d = first_s1 ? '0    : hcount_q;
		fb_d     = first_s1 ? '0    : fb_q;
		fin_d    = first_s1 ? 1'b0  : fin_q;
		if (!valid_s1) begin
			cnt_d    = cnt_q;
			taken_d  = taken_q;
			prev_d   = prev_q;
			havep_d  = havep_q;
			ord_d    = ord_q;
			hside_d  = hside_q;
			hmove_d  = hmove_q;
			hcount_d = hcount_q;
			fb_d     = fb_q;
			fin_d    = fin_q;
		end

		fail  = 1'b0;
		fst   = ST_OK;
		foff  = '0;
		piece = 1'b0;

		off  = cnt_d;
		pos  = off[1:0];
		fb   = (pos == 2'd0) ? 32'd0 : fb_d;
		fb   = fb | (32'(data_s1) << {pos, 3'b000});
		lo   = fb[15:0];
		hi   = fb[31:16];
		code = fb[7:0];
		sq   = fb[15:8];
		base = {off[CNT_W-1:2], 2'b00};

		if (valid_s1 && !fin_d) begin
			cnt_d = off + 1'b1;
			fb_d  = fb;
			if (off < CNT_W'(HDR_BYTES)) begin
				// Header: each field is checked on its last byte
				case (off[3:0])
					4'd0: begin
						if (plen_q < 16'(HDR_BYTES)) begin
							fail = 1'b1; fst = ST_SHORT; foff = 16'd0;
						end
					end
					4'd1: begin
						if (lo != 16'd1) begin
							fail = 1'b1; fst = ST_VERSION; foff = 16'd0;
						end
					end
					4'd3: begin
						if (hi != 16'(HDR_BYTES)) begin
							fail = 1'b1; fst = ST_HDR_SIZE; foff = 16'd2;
						end
					end
					4'd5: begin
						if (lo != 16'd1) begin
							fail = 1'b1; fst = ST_VARIANT; foff = 16'd4;
						end
					end
					4'd6: begin
						if (data_s1 > 8'd1) begin
							fail = 1'b1; fst = ST_SIDE; foff = 16'd6;
						end else begin
							hside_d = data_s1[0];
						end
					end
					4'd7: begin
						if (data_s1 != 8'd0) begin
							fail = 1'b1; fst = ST_FLAGS; foff = 16'd7;
						end
					end
					4'd9: begin
						hmove_d = lo;
						if (lo == 16'd0) begin
							fail = 1'b1; fst = ST_MOVE_ZERO; foff = 16'd8;
						end
					end
					4'd11: begin
						if (hi > 16'(MAX_PIECES)) begin
							fail = 1'b1; fst = ST_TOO_MANY; foff = 16'd10;
						end else begin
							hcount_d = PC_W'(hi);
						end
					end
					4'd15: begin
						if (fb != 32'd0) begin
							fail = 1'b1; fst = ST_RESERVED; foff = 16'd12;
						end else if (plen_q != 16'(HDR_BYTES) + (16'(hcount_d) << 2)) begin
							fail = 1'b1; fst = ST_SIZE; foff = 16'd10;
						end else if (hcount_d == '0) begin
							// Empty position ends the run cleanly
							fail = 1'b1; fst = ST_OK; foff = 16'd0;
						end
					end
					default: begin
					end
				endcase
			end else begin
				// Piece record: code, square, two flag bytes
				case (pos)
					2'd0: begin
						if ((code & 8'h70) != 8'd0 || code[3:0] == 4'd0 || code[3:0] > 4'd7) begin
							fail = 1'b1; fst = ST_PIECE_CODE; foff = 16'(base);
						end
					end
					2'd1: begin
						if (sq > 8'(SQ_MAX)) begin
							fail = 1'b1; fst = ST_SQ_RANGE; foff = 16'(base) + 16'd1;
						end
					end
					2'd2: begin
					end
					default: begin
						if (hi != 16'd0) begin
							fail = 1'b1; fst = ST_PIECE_FLAGS; foff = 16'(base) + 16'd2;
						end else if (taken_d[sq[SQ_W-1:0]]) begin
							fail = 1'b1; fst = ST_DUPLICATE; foff = 16'(base) + 16'd1;
						end else begin
							taken_d[sq[SQ_W-1:0]] = 1'b1;
							if (havep_d && sq[SQ_W-1:0] <= prev_d) begin
								ord_d = 1'b0;
							end
							prev_d  = sq[SQ_W-1:0];
							havep_d = 1'b1;
							piece   = 1'b1;
						end
					end
				endcase
			end
		end

		end_len = 16'(HDR_BYTES) + (16'(hcount_d) << 2);

		push0 = 1'b0;
		push1 = 1'b0;

		res1                 = '0;
		res1.kind            = KIND_SUMMARY;
		res1.status          = fst;
		res1.error_offset    = foff;
		res1.mover_side      = hside_d;
		res1.move_number     = hmove_d;
		res1.pieces_declared = OUT_PC_W'(hcount_d);
		res1.canonical       = ord_d;
		res1.last            = 1'b1;

		res0 = res1;

		if (piece) begin
			push0              = 1'b1;
			res0.kind          = KIND_PIECE;
			res0.status        = ST_OK;
			res0.error_offset  = '0;
			res0.piece_side    = code[7];
			res0.piece_kind    = code[2:0];
			res0.board_square  = sq[6:0];
			res0.last          = 1'b0;
			// Last record also closes the run
			if (16'(off) + 16'd1 >= end_len) begin
				push1 = 1'b1;
				fin_d = 1'b1;
			end
		end else if (fail) begin
			push0 = 1'b1;
			fin_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			taken_q  <= '0;
			prev_q   <= '0;
			havep_q  <= 1'b0;
			ord_q    <= 1'b1;
			hside_q  <= 1'b0;
			hmove_q  <= '0;
			hcount_q <= '0;
			fb_q     <= '0;
			fin_q    <= 1'b1;
		end else begin
			cnt_q    <= cnt_d;
			taken_q  <= taken_d;
			prev_q   <= prev_d;
			havep_q  <= havep_d;
			ord_q    <= ord_d;
			hside_q  <= hside_d;
			hmove_q  <= hmove_d;
			hcount_q <= hcount_d;
			fb_q     <= fb_d;
			fin_q    <= fin_d;
		end
	end

	// ------------------------------------------------------------------
	// Result queue
	// ------------------------------------------------------------------
	result_t           fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FCNT_W-1:0] fcnt_q;
	logic              pop;
	logic [FCNT_W-1:0] n_push;
	logic [FCNT_W-1:0] committed;
	result_t           head;

	assign pop       = out_valid && out_ready;
	assign n_push    = FCNT_W'(push0) + FCNT_W'(push1);
	// Hold room for two results of the item in the input register
	assign committed = fcnt_q + (valid_s1 ? FCNT_W'(2) : '0);
	assign in_ready  = committed <= FCNT_W'(FIFO_DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fcnt_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			fcnt_q   <= fcnt_q + n_push - FCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (push1) begin
			fifo_q[wr_ptr_q + PTR_W'(1)] <= res1;
		end
	end

	assign head            = fifo_q[rd_ptr_q];
	assign out_valid       = fcnt_q != '0;
	assign kind            = head.kind;
	assign status          = head.status;
	assign error_offset    = head.error_offset;
	assign mover_side      = head.mover_side;
	assign move_number     = head.move_number;
	assign pieces_declared = head.pieces_declared;
	assign canonical       = head.canonical;
	assign piece_side      = head.piece_side;
	assign piece_kind      = head.piece_kind;
	assign board_square    = head.board_square;
	assign last            = head.last;

endmodule : board_position_record_validator_top

`default_nettype wire

// File: tb/sv/tb_board_position_record_validator_top.sv
// ----------------------------------------------------------------------------
// Board position record validator testbench
// Streams board-position payloads into the validator one byte at a time,
// mostly well-formed positions with random content plus damaged copies of
// them, and compares every piece and summary result field by field with an
// in-bench model of the header and record checks. Both channels idle in
// random bursts, and the result side holds off once long enough to fill the
// block and stall its input.
// ----------------------------------------------------------------------------

module tb_board_position_record_validator_top;

	import bprv_pkg::*;

	// Header field values that a well-formed payload carries
	localparam bit [15:0] FORMAT_VERSION = 16'd1;
	localparam bit [15:0] BOARD_VARIANT  = 16'd1;

	// Cycles to let an item with no result clear the input register
	localparam int DRAIN_CYCLES = 4;
	// Cycles to watch for stray results once nothing is expected
	localparam int END_CYCLES   = 16;
	// Cycles without any handshake before the run is declared hung
	localparam int STALL_LIMIT  = 1000;
	// Long result-side hold-off: when it starts and how long it lasts
	localparam int HOLD_AT      = 700;
	localparam int HOLD_CYCLES  = 64;

	typedef bit [7:0] byte_q[$];

	// Ways to damage a well-formed payload
	typedef enum int {
		DMG_VERSION,
		DMG_HDR_SIZE,
		DMG_VARIANT,
		DMG_SIDE,
		DMG_FLAGS,
		DMG_MOVE_ZERO,
		DMG_COUNT,
		DMG_RESERVED,
		DMG_PIECE_CODE,
		DMG_SQUARE,
		DMG_PIECE_FLAGS,
		DMG_DUPLICATE,
		DMG_TRUNCATE,
		DMG_SCRAMBLE
	} damage_e;

	// ------------------------------------------------------------------------
	// Scoreboard: tracks the run state of the validator and holds the results
	// that accepted bytes are due to produce, oldest first.
	// ------------------------------------------------------------------------
	class position_scoreboard;
		bit [15:0]          length_reg;
		bit                 idle = 1'b1;
		int unsigned        offset_count;
		bit [N_SQUARES-1:0] occupied;
		bit [6:0]           last_square;
		bit                 seen_square;
		bit                 ascending = 1'b1;
		bit                 side_seen;
		bit [15:0]          move_seen;
		int unsigned        count_seen;
		bit [31:0]          word_buf;
		result_t            expected_results[$];
		int                 errors;

		function void restart_run();
			offset_count = 0;
			occupied     = '0;
			last_square  = '0;
			seen_square  = 1'b0;
			ascending    = 1'b1;
			side_seen    = 1'b0;
			move_seen    = '0;
			count_seen   = 0;
			word_buf     = '0;
		endfunction

		function void emit(bit k, status_t st, bit [15:0] offs, bit ps, bit [2:0] pk,
				bit [6:0] sq, bit lst);
			result_t r;
			r.kind            = k;
			r.status          = st;
			r.error_offset    = offs;
			r.mover_side      = side_seen;
			r.move_number     = move_seen;
			r.pieces_declared = OUT_PC_W'(count_seen);
			r.canonical       = ascending;
			r.piece_side      = ps;
			r.piece_kind      = pk;
			r.board_square    = sq;
			r.last            = lst;
			expected_results.insert(expected_results.size(), r);
		endfunction

		// End the run with a summary and go idle
		function void close_run(status_t st, bit [15:0] offs);
			emit(KIND_SUMMARY, st, offs, 1'b0, 3'd0, 7'd0, 1'b1);
			idle = 1'b1;
		endfunction

		// Note one accepted byte; returns 1 unless the block ignores it
		function bit take_byte(bit [7:0] b, bit f);
			int unsigned off;
			int unsigned pos;
			int unsigned base;
			bit [15:0]   lo;
			bit [15:0]   hi;
			bit [7:0]    code;
			bit [7:0]    sq;
			bit [3:0]    ptype;
			if (f) begin
				restart_run();
				idle = 1'b0;
			end
			if (idle)
				return 1'b0;
			off = offset_count;
			offset_count++;
			pos = off % REC_BYTES;
			if (pos == 0)
				word_buf = '0;
			word_buf |= 32'(b) << (8 * pos);
			lo = word_buf[15:0];
			hi = word_buf[31:16];

			if (off < HDR_BYTES) begin
				case (off)
					0: if (length_reg < HDR_BYTES) close_run(ST_SHORT, 16'd0);
					1: if (lo != FORMAT_VERSION) close_run(ST_VERSION, 16'd0);
					3: if (hi != HDR_BYTES) close_run(ST_HDR_SIZE, 16'd2);
					5: if (lo != BOARD_VARIANT) close_run(ST_VARIANT, 16'd4);
					6: begin
						if (b > 1) close_run(ST_SIDE, 16'd6);
						else side_seen = b[0];
					end
					7: if (b != 0) close_run(ST_FLAGS, 16'd7);
					9: begin
						move_seen = lo;
						if (lo == 0) close_run(ST_MOVE_ZERO, 16'd8);
					end
					11: begin
						if (hi > MAX_PIECES) close_run(ST_TOO_MANY, 16'd10);
						else count_seen = hi;
					end
					15: begin
						if (word_buf != 0)
							close_run(ST_RESERVED, 16'd12);
						else if (length_reg != HDR_BYTES + REC_BYTES * count_seen)
							close_run(ST_SIZE, 16'd10);
						else if (count_seen == 0)
							close_run(ST_OK, 16'd0);
					end
					default: ;
				endcase
				return 1'b1;
			end

			base  = off - pos;
			code  = word_buf[7:0];
			sq    = word_buf[15:8];
			ptype = code[3:0];
			case (pos)
				0: if (code[6:4] != 0 || ptype < 1 || ptype > 7)
					close_run(ST_PIECE_CODE, 16'(base));
				1: if (sq > SQ_MAX) close_run(ST_SQ_RANGE, 16'(base + 1));
				3: begin
					if (hi != 0) begin
						close_run(ST_PIECE_FLAGS, 16'(base + 2));
					end else if (occupied[sq]) begin
						close_run(ST_DUPLICATE, 16'(base + 1));
					end else begin
						occupied[sq] = 1'b1;
						if (seen_square && sq <= last_square)
							ascending = 1'b0;
						last_square = sq[6:0];
						seen_square = 1'b1;
						emit(KIND_PIECE, ST_OK, 16'd0, code[7], ptype[2:0], sq[6:0], 1'b0);
						if (off + 1 >= HDR_BYTES + REC_BYTES * count_seen)
							close_run(ST_OK, 16'd0);
					end
				end
				default: ;
			endcase
			return 1'b1;
		endfunction

		function bit same(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
				return 1'b0;
			end
			return 1'b1;
		endfunction

		// Compare one accepted result with the oldest expectation
		function void check_result(result_t got);
			result_t want;
			bit      ok;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			ok = 1'b1;
			ok &= same("kind", want.kind, got.kind);
			ok &= same("status", want.status, got.status);
			ok &= same("error_offset", want.error_offset, got.error_offset);
			ok &= same("mover_side", want.mover_side, got.mover_side);
			ok &= same("move_number", want.move_number, got.move_number);
			ok &= same("pieces_declared", want.pieces_declared, got.pieces_declared);
			ok &= same("canonical", want.canonical, got.canonical);
			ok &= same("piece_side", want.piece_side, got.piece_side);
			ok &= same("piece_kind", want.piece_kind, got.piece_kind);
			ok &= same("board_square", want.board_square, got.board_square);
			ok &= same("last", want.last, got.last);
			if (!ok)
				errors++;
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Signals: every block input starts at a known value
	// ------------------------------------------------------------------------
	logic                clk;
	logic                arst_n         = 1'b0;
	logic                cfg_valid      = 1'b0;
	logic                cfg_ready;
	logic [15:0]         payload_length = '0;
	logic                in_valid       = 1'b0;
	logic                in_ready;
	logic [7:0]          data_byte      = '0;
	logic                first          = 1'b0;
	logic                out_valid;
	logic                out_ready      = 1'b0;
	logic                kind;
	logic [3:0]          status;
	logic [15:0]         error_offset;
	logic                mover_side;
	logic [15:0]         move_number;
	logic [OUT_PC_W-1:0] pieces_declared;
	logic                canonical;
	logic                piece_side;
	logic [2:0]          piece_kind;
	logic [6:0]          board_square;
	logic                last;

	position_scoreboard board_check = new;

	// Bytes the block actually checks (ignored idle bytes do not count)
	int unsigned checked_bytes;
	// Random idling on both sides; gaps_allowed turns it off for the tail
	bit          gaps_allowed;
	bit          bursty;
	bit          held_off;

	board_position_record_validator_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.payload_length (payload_length),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.first          (first),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.status         (status),
		.error_offset   (error_offset),
		.mover_side     (mover_side),
		.move_number    (move_number),
		.pieces_declared(pieces_declared),
		.canonical      (canonical),
		.piece_side     (piece_side),
		.piece_kind     (piece_kind),
		.board_square   (board_square),
		.last           (last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Payload builders
	// ------------------------------------------------------------------------

	// Build a well-formed position: valid header, the given number of pieces
	// on distinct squares, optionally in ascending square order.
	function automatic byte_q make_position(int unsigned pieces, bit sorted);
		byte_q                   p;
		bit [8*HDR_BYTES-1:0]    hdr;
		bit [N_SQUARES-1:0]      used;
		int unsigned             picks[$];
		int unsigned             sq;
		hdr          = '0;
		hdr[15:0]    = FORMAT_VERSION;
		hdr[31:16]   = 16'(HDR_BYTES);
		hdr[47:32]   = BOARD_VARIANT;
		hdr[55:48]   = 8'($urandom_range(0, 1));
		hdr[79:64]   = 16'($urandom_range(1, 16'hFFFF));
		hdr[95:80]   = 16'(pieces);
		for (int i = 0; i < HDR_BYTES; i++)
			p.insert(p.size(), hdr[8*i +: 8]);
		used = '0;
		repeat (pieces) begin
			do sq = $urandom_range(0, SQ_MAX); while (used[sq]);
			used[sq] = 1'b1;
			picks.insert(picks.size(), sq);
		end
		// Ascending order keeps the canonical flag set to the end
		if (sorted) begin
			picks.delete();
			for (int s = 0; s < N_SQUARES; s++)
				if (used[s])
					picks.insert(picks.size(), s);
		end
		foreach (picks[i]) begin
			p.insert(p.size(), {1'($urandom_range(0, 1)), 4'b0000, 3'($urandom_range(1, 7))});
			p.insert(p.size(), 8'(picks[i]));
			p.insert(p.size(), 8'h00);
			p.insert(p.size(), 8'h00);
		end
		return p;
	endfunction

	// Break one field of a well-formed payload, aiming at one check
	function automatic byte_q damage(byte_q p, int unsigned pieces);
		damage_e     how;
		int unsigned rec;
		int unsigned i;
		int unsigned j;
		how = damage_e'($urandom_range(DMG_VERSION, DMG_SCRAMBLE));
		if (pieces == 0 && how >= DMG_PIECE_CODE && how <= DMG_DUPLICATE)
			how = DMG_SCRAMBLE;
		if (pieces < 2 && how == DMG_DUPLICATE)
			how = DMG_SQUARE;
		rec = (pieces == 0) ? 0 : HDR_BYTES + REC_BYTES * $urandom_range(0, pieces - 1);
		case (how)
			DMG_VERSION:     p[$urandom_range(0, 1)] = 8'($urandom);
			DMG_HDR_SIZE:    p[$urandom_range(2, 3)] = 8'($urandom);
			DMG_VARIANT:     p[$urandom_range(4, 5)] = 8'($urandom);
			DMG_SIDE:        p[6] = 8'($urandom_range(2, 255));
			DMG_FLAGS:       p[7] = 8'($urandom_range(1, 255));
			DMG_MOVE_ZERO: begin
				p[8] = 8'h00;
				p[9] = 8'h00;
			end
			// Any count: too many, a length mismatch, or now and then still right
			DMG_COUNT: begin
				p[10] = 8'($urandom);
				p[11] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
			end
			DMG_RESERVED:    p[$urandom_range(12, 15)] = 8'($urandom_range(1, 255));
			DMG_PIECE_CODE:  p[rec] = 8'($urandom);
			DMG_SQUARE:      p[rec + 1] = 8'($urandom_range(SQ_MAX + 1, 255));
			DMG_PIECE_FLAGS: p[rec + $urandom_range(2, 3)] = 8'($urandom_range(1, 255));
			// Copy an earlier piece's square into a later record
			DMG_DUPLICATE: begin
				j = $urandom_range(1, pieces - 1);
				i = $urandom_range(0, j - 1);
				p[HDR_BYTES + REC_BYTES * j + 1] = p[HDR_BYTES + REC_BYTES * i + 1];
			end
			// Cut the payload short; the next byte marked first drops the run
			DMG_TRUNCATE: repeat ($urandom_range(1, p.size() - 1)) void'(p.pop_back());
			default:         p[$urandom_range(0, p.size() - 1)] = 8'($urandom);
		endcase
		return p;
	endfunction

	// ------------------------------------------------------------------------
	// Drivers: every task starts and returns at a falling edge
	// ------------------------------------------------------------------------

	// Offer one byte and hold it until the block takes it
	task automatic send_byte(bit [7:0] b, bit f);
		if (bursty && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		first     <= f;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (board_check.take_byte(b, f))
			checked_bytes++;
		@(negedge clk);
	endtask

	// Send a payload; once the run has ended, drop the rest, except for a
	// few trailing bytes now and then that the block must ignore.
	task automatic send_payload(byte_q p);
		int unsigned extra;
		extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		foreach (p[i]) begin
			if (i > 0 && board_check.idle) begin
				if (extra == 0)
					break;
				extra--;
			end
			send_byte(p[i], i == 0);
		end
	endtask

	// Hold the input until every expected result is out and the last
	// byte has left the pipeline
	task automatic settle();
		in_valid <= 1'b0;
		while (board_check.expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_length(bit [15:0] value);
		cfg_valid      <= 1'b1;
		payload_length <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board_check.length_reg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One length setting, then payloads until the quota of checked bytes.
	// Where the length fits a legal piece count, payloads use that count;
	// otherwise a random one, and undamaged ones end in a size or short error.
	task automatic run_phase(bit [15:0] length, int unsigned quota);
		int unsigned stop_at;
		int unsigned pieces;
		int unsigned room;
		bit          fits;
		byte_q       p;
		settle();
		write_length(length);
		room = (length >= HDR_BYTES) ? length - HDR_BYTES : 0;
		fits = length >= HDR_BYTES && room % REC_BYTES == 0 && room / REC_BYTES <= MAX_PIECES;
		stop_at = checked_bytes + quota;
		while (checked_bytes < stop_at) begin
			pieces = fits ? room / REC_BYTES : $urandom_range(0, 8);
			p = make_position(pieces, $urandom_range(0, 2) == 0);
			if ($urandom_range(0, 4) < 2)
				p = damage(p, pieces);
			bursty = gaps_allowed && $urandom_range(0, 3) != 0;
			send_payload(p);
			// Stray byte while idle: must be dropped without a result
			if (board_check.idle && $urandom_range(0, 7) == 0)
				send_byte(8'($urandom), 1'b0);
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		byte_q p;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Short payload: length below the header size fails at the first byte.
		// A byte before any payload start must be ignored.
		write_length(16'd0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h01, 1'b1);

		// Bad version, then a run dropped by a restart, then a header-only
		// position that ends with an ok summary at the size check
		settle();
		write_length(16'(HDR_BYTES));
		send_byte(8'h02, 1'b1);
		send_byte(8'h00, 1'b0);
		p = make_position(0, 1'b1);
		p[6] = 8'h01;
		p[8] = 8'hFF;
		p[9] = 8'hFF;
		send_byte(p[0], 1'b1);
		send_byte(p[1], 1'b0);
		send_byte(p[2], 1'b0);
		send_payload(p);

		// Random part: small piece counts mostly, the full 32 once,
		// then lengths that can never match, then legal lengths again
		gaps_allowed = 1'b1;
		run_phase(16'd20, 150);
		run_phase(16'd24, 150);
		run_phase(16'd28, 120);
		run_phase(16'd36, 150);
		run_phase(16'd48, 160);
		run_phase(16'd80, 160);
		run_phase(16'(HDR_BYTES + REC_BYTES * MAX_PIECES), 220);
		run_phase(16'hFFFF, 60);
		run_phase(16'($urandom_range(1, HDR_BYTES - 1)), 30);
		run_phase(16'(HDR_BYTES), 40);
		run_phase(16'(HDR_BYTES + REC_BYTES * $urandom_range(0, MAX_PIECES)), 100);

		// Tail at full rate on both sides
		gaps_allowed = 1'b0;
		run_phase(16'd32, 80);

		settle();
		repeat (END_CYCLES) @(negedge clk);
		if (board_check.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Result side: random stalls, plus one long hold-off while the sender
	// keeps offering bytes so that the result queue fills and the input stalls
	// ------------------------------------------------------------------------
	initial begin : result_sink
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!held_off && checked_bytes >= HOLD_AT) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				held_off = 1'b1;
			end else if (bursty && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	// Sample each accepted result at the rising edge and check it
	always @(posedge clk) begin : result_monitor
		result_t seen;
		if (arst_n && out_valid && out_ready) begin
			seen.kind            = kind;
			seen.status          = status_t'(status);
			seen.error_offset    = error_offset;
			seen.mover_side      = mover_side;
			seen.move_number     = move_number;
			seen.pieces_declared = pieces_declared;
			seen.canonical       = canonical;
			seen.piece_side      = piece_side;
			seen.piece_kind      = piece_kind;
			seen.board_square    = board_square;
			seen.last            = last;
			board_check.check_result(seen);
		end
	end

	// Hang detection: count cycles in which no channel moves an item
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("DONE: errors detected");
		$finish;
	end

endmodule
